// ----- rtl/core/assert_macros.svh -----
// ============================================================================
// assert_macros.svh
// Shared assertion macros for the key gesture event detector RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held
`define KGED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset
`define KGED_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/kged_pkg.sv -----
// ============================================================================
// kged_pkg
// Types, constants and command/status bundles of the key gesture detector.
// ============================================================================
package kged_pkg;

    // Geometry
    localparam int NUM_KEYS    = 6;
    localparam int KEY_W       = 3;
    localparam int TIMER_WIDTH = 16;
    localparam int DEB_W       = 8;
    localparam int LIM_W       = 16;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;
    localparam int KIND_W      = 3;
    localparam int CNT_W       = 2;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

    // Register reset values
    localparam logic [DEB_W-1:0]    RST_DEBOUNCE = DEB_W'(2);
    localparam logic [LIM_W-1:0]    RST_LONG     = LIM_W'(60);
    localparam logic [LIM_W-1:0]    RST_GAP      = LIM_W'(30);
    localparam logic [NUM_KEYS-1:0] RST_MASK     = NUM_KEYS'(1);

    // Event codes
    typedef enum logic [KIND_W-1:0] {
        EV_PRESS   = 3'd0,
        EV_RELEASE = 3'd1,
        EV_LONG    = 3'd2,
        EV_DOUBLE  = 3'd3,
        EV_CLICK   = 3'd4
    } t_event_kind;

    // Register map (word index)
    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_LONG     = 2'd1,
        REG_GAP      = 2'd2,
        REG_MASK     = 2'd3
    } t_reg_idx;

    // Configuration bundle
    typedef struct packed {
        logic [DEB_W-1:0]    debounce;
        logic [LIM_W-1:0]    long_lim;
        logic [LIM_W-1:0]    gap;
        logic [NUM_KEYS-1:0] mask;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic             load_pins;
        logic             scan;
        logic             emit;
        logic [KEY_W-1:0] key;
        logic             sub;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic             out_free;
        logic [CNT_W-1:0] ev_cnt;
    } t_sts;

endpackage

// ----- rtl/core/kged_cfg.sv -----
// ============================================================================
// kged_cfg
// APB register file: debounce, long-press and gap limits, key polarity.
// ============================================================================
module kged_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kged_pkg::ADDR_W-1:0]    paddr,
    input  logic [kged_pkg::DATA_W-1:0]    pwdata,
    output logic [kged_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output kged_pkg::t_cfg                 o_cfg
);

    kged_pkg::t_cfg     r_cfg;
    kged_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = kged_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce <= kged_pkg::RST_DEBOUNCE;
            r_cfg.long_lim <= kged_pkg::RST_LONG;
            r_cfg.gap      <= kged_pkg::RST_GAP;
            r_cfg.mask     <= kged_pkg::RST_MASK;
        end else if (w_wr) begin
            unique case (w_idx)
                kged_pkg::REG_DEBOUNCE: r_cfg.debounce <= pwdata[kged_pkg::DEB_W-1:0];
                kged_pkg::REG_LONG:     r_cfg.long_lim <= pwdata[kged_pkg::LIM_W-1:0];
                kged_pkg::REG_GAP:      r_cfg.gap      <= pwdata[kged_pkg::LIM_W-1:0];
                kged_pkg::REG_MASK:     r_cfg.mask     <= pwdata[kged_pkg::NUM_KEYS-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (w_idx)
            kged_pkg::REG_DEBOUNCE: prdata = kged_pkg::DATA_W'(r_cfg.debounce);
            kged_pkg::REG_LONG:     prdata = kged_pkg::DATA_W'(r_cfg.long_lim);
            kged_pkg::REG_GAP:      prdata = kged_pkg::DATA_W'(r_cfg.gap);
            kged_pkg::REG_MASK:     prdata = kged_pkg::DATA_W'(r_cfg.mask);
            default:                prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/kged_dp.sv -----
// ============================================================================
// kged_dp
// Datapath: per-key debounce and gesture state, one key per scan cycle,
// per-key event slots and the output word register.
// ============================================================================
`include "assert_macros.svh"

module kged_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  kged_pkg::t_cfg                      i_cfg,
    input  kged_pkg::t_cmd                      i_cmd,
    output kged_pkg::t_sts                      o_sts,
    input  logic [kged_pkg::NUM_KEYS-1:0]       i_pins,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] key_index, [5:3] event_kind, [7:6] zero
    output logic [kged_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int NK = kged_pkg::NUM_KEYS;
    localparam int TW = kged_pkg::TIMER_WIDTH;

    // Latched scan tick
    logic [NK-1:0] r_pins;

    // Per-key gesture state
    logic                          r_prev   [NK];
    logic                          r_deb    [NK];
    logic [kged_pkg::DEB_W-1:0]    r_stable [NK];
    logic [TW-1:0]                 r_held   [NK];
    logic [TW-1:0]                 r_rel    [NK];
    logic                          r_click  [NK];
    logic                          r_long   [NK];

    // Per-key event slots filled during the scan
    logic [kged_pkg::CNT_W-1:0]    r_slot_cnt [NK];
    kged_pkg::t_event_kind         r_slot_k0  [NK];
    kged_pkg::t_event_kind         r_slot_k1  [NK];
    logic [kged_pkg::KEY_W-1:0]    r_last_key;

    // Output word register
    logic                          r_out_valid;
    logic [kged_pkg::KEY_W-1:0]    r_out_key;
    kged_pkg::t_event_kind         r_out_kind;
    logic                          r_out_last;

    // Step results for the key under scan
    logic                          w_raw;
    logic                          n_prev, n_deb, n_click, n_long;
    logic [kged_pkg::DEB_W-1:0]    n_stable;
    logic [TW-1:0]                 n_held, n_rel;
    logic [TW-1:0]                 w_held_inc, w_rel_inc;
    logic [kged_pkg::CNT_W-1:0]    w_ev_n;
    kged_pkg::t_event_kind         w_k0, w_k1;
    logic [kged_pkg::KEY_W-1:0]    w_key;

    // Emit side
    logic [kged_pkg::CNT_W-1:0]    w_cnt;
    kged_pkg::t_event_kind         w_emit_kind;
    logic                          w_emit_last;

    assign w_key = i_cmd.key;

    // Per-key step, mirrors the debounce and gesture rules
    always_comb begin
        w_raw      = (r_pins[w_key] == i_cfg.mask[w_key]);
        w_held_inc = (r_held[w_key] == kged_pkg::TIMER_MAX) ? r_held[w_key]
                                                            : r_held[w_key] + 1'b1;
        w_rel_inc  = (r_rel[w_key] == kged_pkg::TIMER_MAX) ? r_rel[w_key]
                                                           : r_rel[w_key] + 1'b1;
        n_prev   = r_prev[w_key];
        n_deb    = r_deb[w_key];
        n_stable = r_stable[w_key];
        n_held   = r_held[w_key];
        n_rel    = r_rel[w_key];
        n_click  = r_click[w_key];
        n_long   = r_long[w_key];
        w_ev_n   = '0;
        w_k0     = kged_pkg::EV_PRESS;
        w_k1     = kged_pkg::EV_DOUBLE;
        priority if (w_raw != r_prev[w_key]) begin
            n_stable = '0;
            n_prev   = w_raw;
        end else if (r_stable[w_key] < i_cfg.debounce) begin
            n_stable = r_stable[w_key] + 1'b1;
        end else if (w_raw != r_deb[w_key]) begin
            n_deb  = w_raw;
            n_held = '0;
            if (w_raw) begin
                w_ev_n = 2'd1;
                w_k0   = kged_pkg::EV_PRESS;
                n_long = 1'b0;
                if (r_click[w_key] && (32'(r_rel[w_key]) <= 32'(i_cfg.gap))) begin
                    w_ev_n  = 2'd2;
                    w_k1    = kged_pkg::EV_DOUBLE;
                    n_click = 1'b0;
                end
            end else begin
                w_ev_n = 2'd1;
                w_k0   = kged_pkg::EV_RELEASE;
                if (!r_long[w_key]) begin
                    n_click = 1'b1;
                    n_rel   = '0;
                end
            end
        end else if (r_deb[w_key]) begin
            n_held = w_held_inc;
            if (!r_long[w_key] && (32'(w_held_inc) >= 32'(i_cfg.long_lim))) begin
                w_ev_n  = 2'd1;
                w_k0    = kged_pkg::EV_LONG;
                n_long  = 1'b1;
                n_click = 1'b0;
            end
        end else if (r_click[w_key]) begin
            n_rel = w_rel_inc;
            if (32'(w_rel_inc) > 32'(i_cfg.gap)) begin
                w_ev_n  = 2'd1;
                w_k0    = kged_pkg::EV_CLICK;
                n_click = 1'b0;
            end
        end else begin
            // idle key, nothing changes
        end
    end

    // Per-key state commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NK; k++) begin
                r_prev[k]   <= 1'b0;
                r_deb[k]    <= 1'b0;
                r_stable[k] <= '0;
                r_held[k]   <= '0;
                r_rel[k]    <= '0;
                r_click[k]  <= 1'b0;
                r_long[k]   <= 1'b0;
            end
        end else if (i_cmd.scan) begin
            r_prev[w_key]   <= n_prev;
            r_deb[w_key]    <= n_deb;
            r_stable[w_key] <= n_stable;
            r_held[w_key]   <= n_held;
            r_rel[w_key]    <= n_rel;
            r_click[w_key]  <= n_click;
            r_long[w_key]   <= n_long;
        end
    end

    // Tick latch and event slots, filled once per key per tick
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pins) begin
            r_pins <= i_pins;
        end
        if (i_cmd.scan) begin
            r_slot_cnt[w_key] <= w_ev_n;
            r_slot_k0[w_key]  <= w_k0;
            r_slot_k1[w_key]  <= w_k1;
            if (w_ev_n != '0) begin
                r_last_key <= w_key;
            end
        end
    end

    // Emit side: pick word from slot, flag the tick's final word
    assign w_cnt       = r_slot_cnt[w_key];
    assign w_emit_kind = i_cmd.sub ? r_slot_k1[w_key] : r_slot_k0[w_key];
    assign w_emit_last = (w_key == r_last_key) &&
                         (i_cmd.sub ? (w_cnt == 2'd2) : (w_cnt == 2'd1));

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_key  <= w_key;
            r_out_kind <= w_emit_kind;
            r_out_last <= w_emit_last;
        end
    end

    assign o_sts.out_free = !r_out_valid || m_axis_tready;
    assign o_sts.ev_cnt   = w_cnt;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_kind, r_out_key};
    assign m_axis_tlast  = r_out_last;

    // Checks
    `KGED_ASSERT(a_pair_order,
        (i_cmd.scan && (w_ev_n == 2'd2)) |->
            (w_k0 == kged_pkg::EV_PRESS && w_k1 == kged_pkg::EV_DOUBLE),
        "two events from one key must be press then double click")
    `KGED_ASSERT(a_word_source, $rose(m_axis_tvalid) |-> $past(i_cmd.emit),
        "output word appeared without an emit command")

endmodule

// ----- rtl/core/kged_ctrl.sv -----
// ============================================================================
// kged_ctrl
// Controller: accepts a scan tick, steps the datapath over all keys,
// then walks the event slots and hands words to the output register.
// ============================================================================
`include "assert_macros.svh"

module kged_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  kged_pkg::t_sts  i_sts,
    output kged_pkg::t_cmd  o_cmd
);

    localparam logic [kged_pkg::KEY_W-1:0] KEY_LAST = kged_pkg::KEY_W'(kged_pkg::NUM_KEYS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state                     r_state;
    logic [kged_pkg::KEY_W-1:0] r_key;
    logic                       r_sub;

    logic w_more;
    logic w_done_key;

    // Slot walk decisions
    assign w_more     = ({1'b0, r_sub} < i_sts.ev_cnt);
    assign w_done_key = !w_more ||
                        (i_sts.out_free && (({1'b0, r_sub} + 2'd1) == i_sts.ev_cnt));

    assign s_axis_tready = (r_state == S_IDLE);

    // Commands
    always_comb begin
        o_cmd.load_pins = (r_state == S_IDLE) && s_axis_tvalid;
        o_cmd.scan      = (r_state == S_SCAN);
        o_cmd.emit      = (r_state == S_EMIT) && w_more && i_sts.out_free;
        o_cmd.key       = r_key;
        o_cmd.sub       = r_sub;
    end

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_key   <= '0;
            r_sub   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_SCAN;
                        r_key   <= '0;
                        r_sub   <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (r_key == KEY_LAST) begin
                        r_state <= S_EMIT;
                        r_key   <= '0;
                    end else begin
                        r_key <= r_key + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_done_key) begin
                        r_sub <= 1'b0;
                        if (r_key == KEY_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_key <= r_key + 1'b1;
                        end
                    end else if (o_cmd.emit) begin
                        r_sub <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    `KGED_ASSERT(a_emit_free, o_cmd.emit |-> i_sts.out_free,
        "emit issued while output register is occupied")
    `KGED_ASSERT(a_scan_walk,
        (r_state == S_SCAN && r_key != KEY_LAST) |=>
            (r_state == S_SCAN && r_key == $past(r_key) + 1'b1),
        "scan skipped or repeated a key")
    `KGED_ASSERT(a_sub_bound, (r_state == S_EMIT && r_sub) |-> (i_sts.ev_cnt == 2'd2),
        "second slot word selected for a key without two events")

endmodule

// ----- rtl/core/key_gesture_event_detector.sv -----
// ============================================================================
// key_gesture_event_detector
// Debounces six keys and reports press, release, long press, double click
// and click events per scan tick.
// ============================================================================
// Usage:
//   Slave stream: one word per scan tick, tdata[5:0] holds the raw pin
//   level of each key. Master stream: one word per event, tdata[2:0] key,
//   tdata[5:3] event kind, tlast marks the final event of a tick. A tick that
//   causes no event produces no word.
//   APB port: four registers at byte offsets 0x0 debounce, 0x4 long press,
//   0x8 click gap, 0xC polarity mask; write them while the block is idle.
//   Flow: after a tick is taken the keys are stepped one per cycle,
//   then the event slots are walked in key order, one event word per
//   cycle while the output register is free; keys without events yield
//   no word. A tick yields at most twelve events. All keys share a
//   single step unit, which the scan walks over in turn.
//   Reset: synchronous, active low; registers return to their defaults and
//   all key state clears to released.
//   Stall: a held master tready freezes the walk; the last word of a tick
//   may wait in the output register while the next tick is already taken.
// ============================================================================
module key_gesture_event_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] pin_levels, [7:6] zero
    input  logic [kged_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] key_index, [5:3] event_kind, [7:6] zero
    output logic [kged_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kged_pkg::ADDR_W-1:0]         paddr,
    input  logic [kged_pkg::DATA_W-1:0]         pwdata,
    output logic [kged_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    kged_pkg::t_cfg w_cfg;
    kged_pkg::t_cmd w_cmd;
    kged_pkg::t_sts w_sts;

    kged_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    kged_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    kged_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_pins        (s_axis_tdata[kged_pkg::NUM_KEYS-1:0]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
